FILE: rtl/core/sphere_levelset_velocity_init_defines.svh
`ifndef SPHERE_LEVELSET_VELOCITY_INIT_DEFINES_SVH
`define SPHERE_LEVELSET_VELOCITY_INIT_DEFINES_SVH

// Implication checked in the same cycle; off while reset is high.
`define SVI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sphere init check failed");

// Implication checked from the next cycle on; off while reset is high.
`define SVI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sphere init check failed");

`endif

FILE: rtl/core/svi_pkg.sv
package svi_pkg;

   localparam int unsigned SQ_IN_W     = 56;
   localparam int unsigned ROOT_W      = 28;
   localparam int unsigned RSP_LATENCY = 76;

   localparam logic [3:0] CSR_CENTER   = 4'd0;
   localparam logic [3:0] CSR_RADIUS   = 4'd1;
   localparam logic [3:0] CSR_ORIGIN   = 4'd2;
   localparam logic [3:0] CSR_SIZE     = 4'd3;
   localparam logic [3:0] CSR_EPS      = 4'd4;
   localparam logic [3:0] CSR_RHO_LIQ  = 4'd5;
   localparam logic [3:0] CSR_RHO_GAS  = 4'd6;
   localparam logic [3:0] CSR_VELOCITY = 4'd7;

   typedef struct packed {
      logic [9:0] cell_i;
      logic [9:0] cell_j;
      logic [9:0] cell_k;
   } req_type;

   typedef struct packed {
      logic signed [23:0] levelset;
      logic [15:0]        volume_fraction;
      logic signed [15:0] velocity_x;
      logic signed [15:0] velocity_y;
      logic signed [15:0] velocity_z;
   } rsp_type;

endpackage

FILE: rtl/core/svi_isqrt.sv
module svi_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [svi_pkg::SQ_IN_W-1:0]  in_value,
   output logic                         out_valid,
   output logic [svi_pkg::ROOT_W-1:0]   out_root
);
   import svi_pkg::*;

   typedef struct packed {
      logic [SQ_IN_W-1:0] v;
      logic [SQ_IN_W-1:0] r;
   } sq_type;

   // one result bit per stage, most significant first
   function automatic sq_type sq_step(sq_type x, int k);
      sq_type             y;
      logic [SQ_IN_W-1:0] b;
      b = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
      y = x;
      if (x.v >= x.r + b) begin
         y.v = x.v - (x.r + b);
         y.r = (x.r >> 1) + b;
      end else begin
         y.r = x.r >> 1;
      end
      return y;
   endfunction

   sq_type            sq_in [ROOT_W];
   sq_type            sq_ff [ROOT_W];
   logic [ROOT_W-1:0] vld_ff;

   assign sq_in[0] = sq_step('{v: in_value, r: '0}, 0);

   for (genvar gk = 1; gk < ROOT_W; gk++) begin : g_step
      assign sq_in[gk] = sq_step(sq_ff[gk-1], gk);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_W; k++) sq_ff[k] <= sq_in[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = sq_ff[ROOT_W-1].r[ROOT_W-1:0];

endmodule

FILE: rtl/core/sphere_levelset_velocity_init.sv
// Sphere level set and velocity initializer. Give one cell index triple per
// cycle with start; busy stays low, so a word is taken every cycle. Each word
// yields exactly one result, shown on rsp_payload with rsp_valid for one cycle;
// the receiver cannot stall, and results appear in input order. Each word
// passes through the 28-stage square root and the two 16-stage restoring
// dividers (band fraction and velocity weighting), one quotient bit per
// stage. Write the csr registers only while no word is in flight; a write
// to an index above 7 is dropped.
module sphere_levelset_velocity_init (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  svi_pkg::req_type req_payload,
   output logic             rsp_valid,
   output svi_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [47:0]      csr_wdata
);
   import svi_pkg::*;

   localparam logic [31:0] SINC_C1 = 32'd1766234505;
   localparam logic [31:0] SINC_C2 = 32'd871601792;
   localparam logic [31:0] SINC_C3 = 32'd204818212;
   localparam logic [31:0] SINC_C4 = 32'd28076038;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [15:0] VOF_ONE = 16'h8000;

   localparam int DIV_N = 16;
   localparam int DV0   = 1;
   localparam int U_S   = DV0 + DIV_N;
   localparam int W_S   = U_S + 1;
   localparam int H_S   = W_S + 1;
   localparam int G_S   = H_S + 4;
   localparam int V_S   = G_S + 1;
   localparam int M_S   = V_S + 1;
   localparam int D_S   = M_S + 1;
   localparam int X_S   = D_S + 1;
   localparam int VD0   = X_S + 1;
   localparam int NSTG  = VD0 + DIV_N;

   typedef struct packed {
      logic signed [23:0] phi;
      logic               above;
      logic               below;
      logic               neg;
      logic               lsb;
      logic [15:0]        rem;
      logic [15:0]        quo;
      logic [14:0]        u;
      logic [28:0]        w;
      logic [31:0]        p;
      logic [14:0]        s;
      logic [15:0]        vof;
      logic [31:0]        num;
      logic [31:0]        den;
      logic [2:0]         vneg;
      logic [2:0][31:0]   vrem;
      logic [2:0][15:0]   vlow;
      logic [2:0][15:0]   vquo;
   } work_type;

   // offset of cell centre from drop centre, units of half an LSB
   function automatic logic signed [28:0] f_d(logic [9:0] idx, logic [15:0] org,
                                               logic [15:0] size, logic [15:0] cen);
      logic signed [28:0] o2;
      logic signed [28:0] c2;
      logic [26:0]        m;
      o2 = {{12{org[15]}}, org, 1'b0};
      c2 = {{12{cen[15]}}, cen, 1'b0};
      m  = {16'b0, idx, 1'b1} * {11'b0, size};
      return o2 + $signed({2'b0, m}) - c2;
   endfunction

   function automatic work_type f_phi(logic [ROOT_W-1:0] root, logic [14:0] rad,
                                      logic [14:0] eps);
      work_type           r;
      logic signed [29:0] diff;
      logic [23:0]        mag;
      r    = '0;
      diff = $signed({15'b0, rad}) - $signed({2'b0, root});
      if (diff < -30'sd8388608)     r.phi = 24'sh800000;
      else if (diff > 30'sd8388607) r.phi = 24'sh7FFFFF;
      else                          r.phi = diff[23:0];
      r.above = r.phi > $signed({9'b0, eps});
      r.below = r.phi < -$signed({9'b0, eps});
      r.neg   = r.phi[23];
      mag     = r.neg ? 24'(-r.phi) : r.phi;
      r.rem   = {1'b0, mag[15:1]};
      r.lsb   = mag[0];
      return r;
   endfunction

   function automatic work_type f_ediv(work_type x, logic [14:0] eps, logic first);
      work_type    r;
      logic [16:0] t;
      r = x;
      t = {x.rem, first ? x.lsb : 1'b0};
      if (t >= {2'b0, eps}) begin
         r.rem = 16'(t - {2'b0, eps});
         r.quo = {x.quo[14:0], 1'b1};
      end else begin
         r.rem = t[15:0];
         r.quo = {x.quo[14:0], 1'b0};
      end
      return r;
   endfunction

   // fold |t| onto the first quarter period
   function automatic work_type f_fold(work_type x);
      work_type r;
      r   = x;
      r.u = (x.quo <= 16'd16384) ? x.quo[14:0] : 15'(VOF_ONE - x.quo);
      r.p = SINC_C4;
      return r;
   endfunction

   function automatic work_type f_sq(work_type x);
      work_type r;
      r   = x;
      r.w = {14'b0, x.u} * {14'b0, x.u};
      return r;
   endfunction

   function automatic work_type f_horner(work_type x, logic [31:0] c);
      work_type    r;
      logic [60:0] prod;
      r    = x;
      prod = {29'b0, x.p} * {32'b0, x.w};
      r.p  = c - {1'b0, prod[60:30]};
      return r;
   endfunction

   function automatic work_type f_g(work_type x);
      work_type    r;
      logic [46:0] prod;
      r    = x;
      prod = {32'b0, x.u} * {15'b0, x.p};
      r.s  = prod[44:30];
      return r;
   endfunction

   function automatic work_type f_vof(work_type x);
      work_type           r;
      logic signed [18:0] t;
      logic signed [18:0] s;
      logic signed [18:0] n;
      r = x;
      t = {3'b0, x.quo};
      s = {4'b0, x.s};
      if (x.neg) begin
         t = -t;
         s = -s;
      end
      n = 19'sd32768 + t + s;
      if (n < 19'sd0)          n = '0;
      else if (n > 19'sd65536) n = 19'sd65536;
      r.vof = n[16:1];
      if (x.above)      r.vof = VOF_ONE;
      else if (x.below) r.vof = '0;
      return r;
   endfunction

   function automatic work_type f_mul(work_type x, logic [15:0] rl, logic [15:0] rg);
      work_type r;
      r     = x;
      r.num = {16'b0, x.vof} * {16'b0, rl};
      r.den = {16'b0, 16'(VOF_ONE - x.vof)} * {16'b0, rg};
      return r;
   endfunction

   function automatic work_type f_den(work_type x);
      work_type r;
      r     = x;
      r.den = x.num + x.den;
      return r;
   endfunction

   function automatic work_type f_vmul(work_type x, logic [47:0] velp);
      work_type    r;
      logic [15:0] v;
      logic [15:0] mag;
      logic [47:0] prod;
      r = x;
      for (int l = 0; l < 3; l++) begin
         v         = velp[16*l +: 16];
         r.vneg[l] = v[15];
         mag       = v[15] ? 16'(-v) : v;
         prod      = {32'b0, mag} * {16'b0, x.num};
         r.vrem[l] = prod[47:16];
         r.vlow[l] = prod[15:0];
         r.vquo[l] = '0;
      end
      return r;
   endfunction

   function automatic work_type f_vdiv(work_type x, int k);
      work_type    r;
      logic [32:0] t;
      r = x;
      for (int l = 0; l < 3; l++) begin
         t = {x.vrem[l], x.vlow[l][15-k]};
         if (t >= {1'b0, x.den}) begin
            r.vrem[l] = 32'(t - {1'b0, x.den});
            r.vquo[l] = {x.vquo[l][14:0], 1'b1};
         end else begin
            r.vrem[l] = t[31:0];
            r.vquo[l] = {x.vquo[l][14:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] f_lane(work_type x, int l);
      logic [15:0] q;
      q = x.vneg[l] ? 16'(-x.vquo[l]) : x.vquo[l];
      return (x.den == '0) ? 16'd0 : q;
   endfunction

   function automatic rsp_type f_out(work_type x);
      rsp_type o;
      o.levelset        = x.phi;
      o.volume_fraction = x.vof;
      o.velocity_x      = f_lane(x, 0);
      o.velocity_y      = f_lane(x, 1);
      o.velocity_z      = f_lane(x, 2);
      return o;
   endfunction

   // configuration registers
   logic [47:0] cen_ff, org_ff, size_ff, vel_ff;
   logic [14:0] rad_ff, eps_ff;
   logic [15:0] rl_ff, rg_ff;
   logic [14:0] eps_eff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;
   assign eps_eff   = (eps_ff == '0) ? 15'd1 : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff  <= '0;
         rad_ff  <= '0;
         org_ff  <= '0;
         size_ff <= '0;
         eps_ff  <= 15'd1;
         rl_ff   <= 16'd1;
         rg_ff   <= 16'd1;
         vel_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER:   cen_ff  <= csr_wdata;
            CSR_RADIUS:   rad_ff  <= csr_wdata[14:0];
            CSR_ORIGIN:   org_ff  <= csr_wdata;
            CSR_SIZE:     size_ff <= csr_wdata;
            CSR_EPS:      eps_ff  <= csr_wdata[14:0];
            CSR_RHO_LIQ:  rl_ff   <= csr_wdata[15:0];
            CSR_RHO_GAS:  rg_ff   <= csr_wdata[15:0];
            CSR_VELOCITY: vel_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: offsets, squares, sum
   logic                     acc;
   logic [2:0][9:0]          idx_w;
   logic signed [28:0]       d_in [3];
   logic signed [28:0]       d_ff [3];
   logic [55:0]              sq_in [3];
   logic [55:0]              sq_ff [3];
   logic [57:0]              sum_in;
   logic [SQ_IN_W-1:0]       sum_ff;
   logic                     a_vld_ff, b_vld_ff, c_vld_ff;
   logic                     rt_valid;
   logic [ROOT_W-1:0]        rt_root;

   assign acc   = start && !busy;
   assign idx_w = {req_payload.cell_k, req_payload.cell_j, req_payload.cell_i};

   for (genvar ga = 0; ga < 3; ga++) begin : g_axis
      logic [27:0] mag;
      assign d_in[ga]  = f_d(idx_w[ga], org_ff[16*ga +: 16], size_ff[16*ga +: 16],
                             cen_ff[16*ga +: 16]);
      assign mag       = d_ff[ga][28] ? 28'(-d_ff[ga]) : d_ff[ga][27:0];
      assign sq_in[ga] = {28'b0, mag} * {28'b0, mag};
   end

   assign sum_in = {2'b0, sq_ff[0]} + {2'b0, sq_ff[1]} + {2'b0, sq_ff[2]};

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         d_ff[a]  <= d_in[a];
         sq_ff[a] <= sq_in[a];
      end
      sum_ff <= sum_in[57:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= acc;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   svi_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_value  (sum_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root)
   );

   // back: level set, band fraction, sine term, densities, velocity
   localparam logic [31:0] HC [4] = '{SINC_C3, SINC_C2, SINC_C1, Q30_ONE};

   work_type        wk_in [NSTG];
   work_type        wk_ff [NSTG];
   logic [NSTG-1:0] wv_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_payload_ff;

   assign wk_in[0] = f_phi(rt_root, rad_ff, eps_eff);

   for (genvar gd = 0; gd < DIV_N; gd++) begin : g_ediv
      assign wk_in[DV0+gd] = f_ediv(wk_ff[DV0+gd-1], eps_eff, gd == 0);
   end

   assign wk_in[U_S] = f_fold(wk_ff[U_S-1]);
   assign wk_in[W_S] = f_sq(wk_ff[W_S-1]);

   for (genvar gh = 0; gh < 4; gh++) begin : g_horner
      assign wk_in[H_S+gh] = f_horner(wk_ff[H_S+gh-1], HC[gh]);
   end

   assign wk_in[G_S] = f_g(wk_ff[G_S-1]);
   assign wk_in[V_S] = f_vof(wk_ff[V_S-1]);
   assign wk_in[M_S] = f_mul(wk_ff[M_S-1], rl_ff, rg_ff);
   assign wk_in[D_S] = f_den(wk_ff[D_S-1]);
   assign wk_in[X_S] = f_vmul(wk_ff[X_S-1], vel_ff);

   for (genvar gv = 0; gv < DIV_N; gv++) begin : g_vdiv
      assign wk_in[VD0+gv] = f_vdiv(wk_ff[VD0+gv-1], gv);
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) wk_ff[s] <= wk_in[s];
      rsp_payload_ff <= f_out(wk_ff[NSTG-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wv_ff        <= {wv_ff[NSTG-2:0], rt_valid};
         rsp_valid_ff <= wv_ff[NSTG-1];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/core/svi_checker.sv
`include "sphere_levelset_velocity_init_defines.svh"

module svi_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input svi_pkg::rsp_type rsp_payload
);
   import svi_pkg::*;

   // every taken word comes out after the fixed latency
   `SVI_ASSERT_NEXT(a_lat_fwd, clock, reset, start && !busy, ##(RSP_LATENCY-1) rsp_valid)
   // and no result appears without a word taken that long ago
   `SVI_ASSERT_SAME(a_lat_back, clock, reset, rsp_valid, $past(start && !busy, RSP_LATENCY))
   // a full cell lies strictly inside the drop
   `SVI_ASSERT_SAME(a_full_inside, clock, reset,
                    rsp_valid && rsp_payload.volume_fraction == 16'h8000,
                    rsp_payload.levelset > 24'sd0)
   // no liquid, no momentum
   `SVI_ASSERT_SAME(a_dry_still, clock, reset,
                    rsp_valid && rsp_payload.volume_fraction == 16'd0,
                    rsp_payload.velocity_x == 16'sd0 && rsp_payload.velocity_y == 16'sd0
                    && rsp_payload.velocity_z == 16'sd0)

endmodule

bind sphere_levelset_velocity_init svi_checker u_svi_checker (.*);
